/* src/ettr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ettr_pkg: shared types and constants of the ephemeris update filter
// Sizes, payload structs, status codes and the candidate cell interface.
// ----------------------------------------------------------------------------
package ettr_pkg;

   localparam int SIGNAL_COUNT    = 64;
   localparam int CANDIDATE_SLOTS = 8;
   localparam int CONTENT_BITS    = 64;

   localparam int SIG_W      = 6;
   localparam int CONTENT_W  = 64;
   localparam int TIME_W     = 32;
   localparam int AGE_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DB_DEPTH = (SIGNAL_COUNT < (1 << SIG_W)) ? SIGNAL_COUNT : (1 << SIG_W);
   localparam int DB_IDX_W = (DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TAKE_FIRST = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE    = CSR_IDX_W'(1);

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(92);

   typedef enum logic [2:0] {
      STATUS_IDENTICAL = 3'd0,
      STATUS_TRUSTED   = 3'd1,
      STATUS_CANDIDATE = 3'd2,
      STATUS_MISMATCH  = 3'd3,
      STATUS_BAD_PARAM = 3'd4
   } status_type;

   typedef struct packed {
      logic [SIG_W-1:0]     signal_index;
      logic                 eph_valid;
      logic                 eph_healthy;
      logic [CONTENT_W-1:0] eph_content;
      logic [TIME_W-1:0]    now_seconds;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       candidate_added;
   } rsp_type;

   // Stored ephemeris record: content fingerprint plus both flags
   typedef struct packed {
      logic [CONTENT_BITS-1:0] content;
      logic                    valid;
      logic                    healthy;
   } rec_type;

   // Broadcast from the controller to every candidate cell
   typedef struct packed {
      logic [SIG_W-1:0]  sig;
      rec_type           rec;
      logic [TIME_W-1:0] now;
      logic [AGE_W-1:0]  max_age;
      logic              release_en;
      logic              add_en;
   } cell_bcast_type;

   // Priority chain passed from the lower slot to the higher one
   typedef struct packed {
      logic hit;
      logic same;
      logic free;
   } cell_chain_type;

endpackage

/* src/ettr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ettr_cell: one candidate slot
// Holds a pending ephemeris, flags a signal hit or a free slot, and passes
// the priority chain on to the next slot.
// ----------------------------------------------------------------------------
module ettr_cell import ettr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cell_bcast_type bcast,
   input  cell_chain_type chain_i,
   output cell_chain_type chain_o
);

   logic              used_ff;
   logic [SIG_W-1:0]  signal_ff;
   rec_type           content_ff;
   logic [TIME_W-1:0] time_ff;

   logic              my_hit;
   logic              my_free;
   logic [TIME_W-1:0] age;

   assign age     = bcast.now - time_ff;
   assign my_hit  = used_ff && (signal_ff == bcast.sig);
   assign my_free = !used_ff || (age > TIME_W'(bcast.max_age));

   // Only the lowest hit and the lowest free slot act
   assign chain_o.hit  = chain_i.hit | my_hit;
   assign chain_o.same = chain_i.hit ? chain_i.same : (my_hit && (content_ff == bcast.rec));
   assign chain_o.free = chain_i.free | my_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= 1'b0;
         signal_ff <= '0;
      end else if (bcast.release_en && my_hit && !chain_i.hit) begin
         used_ff <= 1'b0;
      end else if (bcast.add_en && my_free && !chain_i.free) begin
         used_ff   <= 1'b1;
         signal_ff <= bcast.sig;
      end
   end

   always_ff @(posedge clock) begin
      if (bcast.add_en && my_free && !chain_i.free) begin
         content_ff <= bcast.rec;
         time_ff    <= bcast.now;
      end
   end

endmodule

/* src/ephemeris_two_receipt_update_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ephemeris_two_receipt_update_filter_unit: two-receipt ephemeris filter
// Refuses bad offers, acknowledges identical ones, and commits new entries
// on a confirming second receipt held in a row of candidate cells, or on the
// first receipt when take-first is set and no usable entry is stored.
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------------
//   request | start, busy, req_data                   | start && !busy
//   result  | rsp_valid, rsp_data                     | one-cycle strobe
//   config  | csr_valid, csr_ready, csr_index, csr_wdata | csr_valid && csr_ready
//
// A transaction is accepted in IDLE; the entry read from the database
// memory is registered at that edge. The next cycle decides, updates the
// database and the candidate cells, and registers the result strobe.
// A new transaction is taken only once the previous one has left DECIDE.
// Reset clears all entry valid bits and candidate slots at once.
// The result side cannot stall; config is taken in any cycle.
// ----------------------------------------------------------------------------
module ephemeris_two_receipt_update_filter_unit import ettr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic {S_IDLE, S_DECIDE} state_type;

   state_type          state_ff;
   req_type            req_ff;
   rec_type            db_rd_ff;
   logic               db_hit_vld_ff;
   logic               take_first_ff;
   logic [AGE_W-1:0]   max_age_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   rec_type            db_mem [DB_DEPTH];
   logic [DB_DEPTH-1:0] db_vld_ff;

   logic               accept;
   logic               deciding;
   logic [DB_IDX_W-1:0] rd_idx;
   logic [DB_IDX_W-1:0] wr_idx;
   rec_type            offer;
   rec_type            existing;
   logic               bad;
   logic               usable;
   logic               identical;
   logic               db_we;
   logic               rel_en;
   logic               add_en;
   status_type         status_in;
   logic               added_in;
   cell_bcast_type     bcast;
   cell_chain_type     chain [CANDIDATE_SLOTS+1];

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign deciding  = (state_ff == S_DECIDE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_idx = req_data.signal_index[DB_IDX_W-1:0];
   assign wr_idx = req_ff.signal_index[DB_IDX_W-1:0];

   assign offer.content = req_ff.eph_content[CONTENT_BITS-1:0];
   assign offer.valid   = req_ff.eph_valid;
   assign offer.healthy = req_ff.eph_healthy;

   // Entry never written reads as all zero
   assign existing  = db_hit_vld_ff ? db_rd_ff : '0;
   assign bad       = !req_ff.eph_valid || (int'(req_ff.signal_index) >= SIGNAL_COUNT);
   assign usable    = existing.valid && existing.healthy;
   assign identical = usable && (existing == offer);

   always_comb begin
      status_in = STATUS_CANDIDATE;
      added_in  = 1'b0;
      rel_en    = 1'b0;
      add_en    = 1'b0;
      if (bad) begin
         status_in = STATUS_BAD_PARAM;
      end else if (identical) begin
         status_in = STATUS_IDENTICAL;
      end else if (chain[CANDIDATE_SLOTS].hit) begin
         rel_en    = 1'b1;
         status_in = chain[CANDIDATE_SLOTS].same ? STATUS_TRUSTED : STATUS_MISMATCH;
      end else if (!usable && take_first_ff) begin
         status_in = STATUS_TRUSTED;
      end else begin
         add_en   = 1'b1;
         added_in = chain[CANDIDATE_SLOTS].free;
      end
   end

   assign db_we = deciding && (status_in == STATUS_TRUSTED);

   assign bcast.sig        = req_ff.signal_index;
   assign bcast.rec        = offer;
   assign bcast.now        = req_ff.now_seconds;
   assign bcast.max_age    = max_age_ff;
   assign bcast.release_en = deciding && rel_en;
   assign bcast.add_en     = deciding && add_en;

   assign chain[0] = '0;

   for (genvar i = 0; i < CANDIDATE_SLOTS; i++) begin : g_cell
      ettr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .bcast   (bcast),
         .chain_i (chain[i]),
         .chain_o (chain[i+1])
      );
   end

   // Database memory: read at accept, write on commit
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_data;
         db_rd_ff <= db_mem[rd_idx];
      end
      if (db_we) begin
         db_mem[wr_idx] <= offer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_vld_ff     <= '0;
         db_hit_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            db_hit_vld_ff <= db_vld_ff[rd_idx];
         end
         if (db_we) begin
            db_vld_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_first_ff <= 1'b1;
         max_age_ff    <= MAX_AGE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TAKE_FIRST: take_first_ff <= csr_wdata[0];
            CSR_MAX_AGE:    max_age_ff    <= csr_wdata[AGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               rsp_valid_ff                <= 1'b1;
               rsp_data_ff.status          <= status_in;
               rsp_data_ff.candidate_added <= added_in;
               state_ff                    <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("transaction without result");

   a_added_only_candidate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.candidate_added |-> rsp_data.status == STATUS_CANDIDATE)
      else $error("candidate_added with wrong status");

   a_commit_trusted: assert property (@(posedge clock) disable iff (reset)
      db_we |=> rsp_valid && rsp_data.status == STATUS_TRUSTED)
      else $error("database written without trusted result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule
